// ----- design/mae_pkg.sv -----
`default_nettype none

package mae_pkg;

   localparam int MAX_DIM = 4;
   localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ELEMS   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = (ELEMS > 1) ? $clog2(ELEMS) : 1;

   localparam int VAL_W       = 32;
   localparam int SIZE_W      = 4;
   localparam int POS_W       = 3;
   localparam int KIND_W      = 2;
   localparam int OP_W        = 3;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;

   localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOAD_C  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd3;

   localparam logic [OP_W-1:0] OP_ADD = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB = 3'd1;
   localparam logic [OP_W-1:0] OP_AB  = 3'd2;
   localparam logic [OP_W-1:0] OP_AC  = 3'd3;
   localparam logic [OP_W-1:0] OP_BC  = 3'd4;
   localparam logic [OP_W-1:0] OP_TRA = 3'd5;
   localparam logic [OP_W-1:0] OP_TRB = 3'd6;

   // One result element as it waits in the output queue.
   typedef struct packed {
      logic             last;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } rsp_entry_type;

   // Control that travels alongside a memory read through the pipeline.
   typedef struct packed {
      logic             first;
      logic             last;
      logic             last_elem;
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } stage_type;

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      elem_addr = ADDR_W'(r * MAX_DIM + c);
   endfunction

endpackage

`default_nettype wire

// ----- design/matrix_arith_engine.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata: row, col, value, operation; tuser: kind
// rsp      out        rsp_tvalid/rsp_tready  tdata: out_row, out_col, out_value; tlast: last
// csr      in         csr_wr_en              csr_wr_data: size_in_use
//
// A load request is written to its store as it is accepted. A compute request issues one
// memory read per cycle while issue is not paused: n*n*n reads for A*B, n*n for A*C, B*C
// and element-wise operations, all through the single multiply-accumulate path.
// The result queue holds four elements; when all four slots are taken by queued or
// in-flight results and rsp is stalled, issue pauses.
// Reset is synchronous, sets the size register to four and clears the valid bits of
// all stores.
`default_nettype none

module matrix_arith_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // row [2:0], col [5:3], value [37:6], operation [40:38], zero [47:41]
   input  logic [mae_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // kind [1:0]
   input  logic [mae_pkg::KIND_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_row [2:0], out_col [5:3], out_value [37:6], zero [39:38]
   output logic [mae_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [mae_pkg::SIZE_W-1:0]         csr_wr_data
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   localparam int IW = mae_pkg::IDX_W;
   localparam int AW = mae_pkg::ADDR_W;
   localparam int VW = mae_pkg::VAL_W;

   // Request decode.
   logic [mae_pkg::POS_W-1:0]  req_row, req_col;
   logic [VW-1:0]              req_value;
   logic [mae_pkg::OP_W-1:0]   req_op;
   logic                       accept, row_ok, col_ok;
   logic                       we_a, we_b, we_c;
   logic [AW-1:0]              wr_addr;

   assign req_row   = req_tdata[2:0];
   assign req_col   = req_tdata[5:3];
   assign req_value = req_tdata[37:6];
   assign req_op    = req_tdata[40:38];
   assign accept    = req_tvalid & req_tready;
   assign row_ok    = {1'b0, req_row} < mae_pkg::SIZE_W'(mae_pkg::MAX_DIM);
   assign col_ok    = {1'b0, req_col} < mae_pkg::SIZE_W'(mae_pkg::MAX_DIM);
   assign wr_addr   = mae_pkg::elem_addr(req_row[IW-1:0], req_col[IW-1:0]);
   assign we_a = accept && (req_tuser == mae_pkg::KIND_LOAD_A) && row_ok && col_ok;
   assign we_b = accept && (req_tuser == mae_pkg::KIND_LOAD_B) && row_ok && col_ok;
   assign we_c = accept && (req_tuser == mae_pkg::KIND_LOAD_C) && row_ok;

   // Size register and its clamped value.
   logic [mae_pkg::SIZE_W-1:0] size_ff, n_eff;
   logic [IW-1:0]              nm1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mae_pkg::SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   always_comb begin
      priority if (size_ff == '0) begin
         n_eff = mae_pkg::SIZE_W'(1);
      end else if (size_ff > mae_pkg::SIZE_W'(mae_pkg::MAX_DIM)) begin
         n_eff = mae_pkg::SIZE_W'(mae_pkg::MAX_DIM);
      end else begin
         n_eff = size_ff;
      end
   end
   assign nm1 = IW'(n_eff - mae_pkg::SIZE_W'(1));

   // Sequencer.
   state_type                 state_ff, state_in;
   logic [mae_pkg::OP_W-1:0]  op_ff, op_in;
   logic [IW-1:0]             nm1_ff, nm1_in;
   logic [IW-1:0]             i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IW-1:0]             kmax, jmax;
   logic                      is_vec, is_mul, last_k, last_j, last_i;
   logic                      issue, credit_ok, pop, push;
   logic [mae_pkg::FIFO_CNT_W-1:0] owed_ff, owed_in;

   assign is_vec = (op_ff == mae_pkg::OP_AC) || (op_ff == mae_pkg::OP_BC);
   assign is_mul = is_vec || (op_ff == mae_pkg::OP_AB);
   assign kmax   = is_mul ? nm1_ff : '0;
   assign jmax   = is_vec ? '0 : nm1_ff;
   assign last_k = (k_ff == kmax);
   assign last_j = (j_ff == jmax);
   assign last_i = (i_ff == nm1_ff);

   // A new element starts only when a queue slot is reserved for its result.
   assign credit_ok = (owed_ff < mae_pkg::FIFO_CNT_W'(mae_pkg::FIFO_DEPTH)) || pop;
   assign issue     = (state_ff == ST_RUN) && ((k_ff != '0) || credit_ok);
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      nm1_in   = nm1_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == mae_pkg::KIND_COMPUTE) &&
                (req_op <= mae_pkg::OP_TRB)) begin
               state_in = ST_RUN;
               op_in    = req_op;
               nm1_in   = nm1;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (!last_k) begin
                  k_in = k_ff + IW'(1);
               end else begin
                  k_in = '0;
                  if (!last_j) begin
                     j_in = j_ff + IW'(1);
                  end else begin
                     j_in = '0;
                     if (last_i) begin
                        state_in = ST_IDLE;
                     end else begin
                        i_in = i_ff + IW'(1);
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      nm1_ff <= nm1_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
   end

   // Read addresses for the current step.
   logic [AW-1:0] ra, rb;
   logic [IW-1:0] rc;
   assign rc = k_ff;

   always_comb begin
      unique case (op_ff)
         mae_pkg::OP_AB: begin
            ra = mae_pkg::elem_addr(i_ff, k_ff);
            rb = mae_pkg::elem_addr(k_ff, j_ff);
         end
         mae_pkg::OP_AC, mae_pkg::OP_BC: begin
            ra = mae_pkg::elem_addr(i_ff, k_ff);
            rb = mae_pkg::elem_addr(i_ff, k_ff);
         end
         mae_pkg::OP_TRA, mae_pkg::OP_TRB: begin
            ra = mae_pkg::elem_addr(j_ff, i_ff);
            rb = mae_pkg::elem_addr(j_ff, i_ff);
         end
         default: begin
            ra = mae_pkg::elem_addr(i_ff, j_ff);
            rb = mae_pkg::elem_addr(i_ff, j_ff);
         end
      endcase
   end

   // Stores: synchronous memories with valid bits that reset clears.
   logic [VW-1:0]             mem_a [mae_pkg::ELEMS];
   logic [VW-1:0]             mem_b [mae_pkg::ELEMS];
   logic [VW-1:0]             mem_c [mae_pkg::MAX_DIM];
   logic [mae_pkg::ELEMS-1:0] vld_a_ff, vld_b_ff;
   logic [mae_pkg::MAX_DIM-1:0] vld_c_ff;
   logic [VW-1:0]             rd_a_ff, rd_b_ff, rd_c_ff;
   logic                      rdv_a_ff, rdv_b_ff, rdv_c_ff;

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[wr_addr] <= req_value;
      end
      if (we_b) begin
         mem_b[wr_addr] <= req_value;
      end
      if (we_c) begin
         mem_c[req_row[IW-1:0]] <= req_value;
      end
      rd_a_ff <= mem_a[ra];
      rd_b_ff <= mem_b[rb];
      rd_c_ff <= mem_c[rc];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= '0;
         vld_b_ff <= '0;
         vld_c_ff <= '0;
      end else begin
         if (we_a) begin
            vld_a_ff[wr_addr] <= 1'b1;
         end
         if (we_b) begin
            vld_b_ff[wr_addr] <= 1'b1;
         end
         if (we_c) begin
            vld_c_ff[req_row[IW-1:0]] <= 1'b1;
         end
      end
      rdv_a_ff <= vld_a_ff[ra];
      rdv_b_ff <= vld_b_ff[rb];
      rdv_c_ff <= vld_c_ff[rc];
   end

   // Stage 1: read data arrives; stage 2: combine or multiply; stage 3: accumulate.
   mae_pkg::stage_type s1_ff, s1_in, s2_ff;
   logic               s1_vld_ff, s2_vld_ff;
   logic [VW-1:0]      opa, opb, opc, s2_val_in, s2_val_ff, acc_ff, acc_in;

   always_comb begin
      s1_in.first     = (k_ff == '0);
      s1_in.last      = last_k;
      s1_in.last_elem = last_i && last_j;
      s1_in.op        = op_ff;
      s1_in.row       = mae_pkg::POS_W'(i_ff);
      s1_in.col       = mae_pkg::POS_W'(j_ff);
   end

   assign opa = rdv_a_ff ? rd_a_ff : '0;
   assign opb = rdv_b_ff ? rd_b_ff : '0;
   assign opc = rdv_c_ff ? rd_c_ff : '0;

   always_comb begin
      unique case (s1_ff.op)
         mae_pkg::OP_ADD: s2_val_in = opa + opb;
         mae_pkg::OP_SUB: s2_val_in = opa - opb;
         mae_pkg::OP_AB:  s2_val_in = opa * opb;
         mae_pkg::OP_AC:  s2_val_in = opa * opc;
         mae_pkg::OP_BC:  s2_val_in = opb * opc;
         mae_pkg::OP_TRA: s2_val_in = opa;
         mae_pkg::OP_TRB: s2_val_in = opb;
         default:         s2_val_in = '0;
      endcase
   end

   // Element-wise operations have a single step, so first is always set for them.
   assign acc_in = s2_ff.first ? s2_val_ff : acc_ff + s2_val_ff;
   assign push   = s2_vld_ff && s2_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
      s1_ff     <= s1_in;
      s2_ff     <= s1_ff;
      s2_val_ff <= s2_val_in;
      if (s2_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Result queue.
   mae_pkg::rsp_entry_type          fifo [mae_pkg::FIFO_DEPTH];
   mae_pkg::rsp_entry_type          push_entry, head;
   logic [mae_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [mae_pkg::FIFO_CNT_W-1:0]  fifo_cnt_ff;

   assign push_entry.last  = s2_ff.last_elem;
   assign push_entry.value = acc_in;
   assign push_entry.col   = s2_ff.col;
   assign push_entry.row   = s2_ff.row;

   assign head       = fifo[rd_ptr_ff];
   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {2'b00, head.value, head.col, head.row};
   assign rsp_tlast  = head.last;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo[wr_ptr_ff] <= push_entry;
      end
   end

   always_comb begin
      owed_in = owed_ff;
      if (issue && (k_ff == '0) && !pop) begin
         owed_in = owed_ff + mae_pkg::FIFO_CNT_W'(1);
      end else if (pop && !(issue && (k_ff == '0))) begin
         owed_in = owed_ff - mae_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         owed_ff     <= '0;
      end else begin
         owed_ff <= owed_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + mae_pkg::FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + mae_pkg::FIFO_PTR_W'(1);
         end
         if (push && !pop) begin
            fifo_cnt_ff <= fifo_cnt_ff + mae_pkg::FIFO_CNT_W'(1);
         end else if (pop && !push) begin
            fifo_cnt_ff <= fifo_cnt_ff - mae_pkg::FIFO_CNT_W'(1);
         end
      end
   end

   // Checks.
   a_owed_bound: assert property (@(posedge clock) disable iff (reset)
      owed_ff <= mae_pkg::FIFO_CNT_W'(mae_pkg::FIFO_DEPTH))
      else $error("more results owed than queue slots");

   a_queue_within_owed: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= owed_ff)
      else $error("queued results exceed results owed");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_cnt_ff < mae_pkg::FIFO_CNT_W'(mae_pkg::FIFO_DEPTH)))
      else $error("result pushed into a full queue");

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      (we_a || we_b || we_c) |-> (state_ff == ST_IDLE))
      else $error("store written while a compute request issues reads");

endmodule

`default_nettype wire

// ----- verif/matrix_arith_engine_tb.sv -----
`default_nettype none

module matrix_arith_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [mae_pkg::OP_W-1:0] OP_NONE = 3'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_PER_PHASE = 18;

   typedef struct packed {
      logic [mae_pkg::KIND_W-1:0] kind;
      logic [mae_pkg::POS_W-1:0]  row;
      logic [mae_pkg::POS_W-1:0]  col;
      logic [mae_pkg::VAL_W-1:0]  value;
      logic [mae_pkg::OP_W-1:0]   op;
   } request_type;

   typedef struct packed {
      logic [mae_pkg::POS_W-1:0] row;
      logic [mae_pkg::POS_W-1:0] col;
      logic [mae_pkg::VAL_W-1:0] value;
      logic                      last;
   } elem_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [mae_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [mae_pkg::KIND_W-1:0]      req_tuser   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [mae_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_wr_en   = 1'b0;
   logic [mae_pkg::SIZE_W-1:0]      csr_wr_data = '0;

   matrix_arith_engine u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the engine's stores and size register.
   logic [mae_pkg::VAL_W-1:0]  mat_a [mae_pkg::MAX_DIM][mae_pkg::MAX_DIM];
   logic [mae_pkg::VAL_W-1:0]  mat_b [mae_pkg::MAX_DIM][mae_pkg::MAX_DIM];
   logic [mae_pkg::VAL_W-1:0]  vec_c [mae_pkg::MAX_DIM];
   logic [mae_pkg::SIZE_W-1:0] size_reg;

   request_type pending_reqs[$];
   elem_type    expected_elems[$];
   int          err_count   = 0;
   int          cycle_count = 0;
   int          rsp_seen    = 0;
   bit          idle_mode   = 1'b1;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int draw_wait();
      if (!idle_mode || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic logic [mae_pkg::VAL_W-1:0] draw_value();
      case ($urandom_range(0, 4))
         0: return mae_pkg::VAL_W'($signed($urandom_range(0, 16)) - 8);
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // Updates the shadow stores for one accepted request and queues the
   // elements a compute request will stream out, in row-major order.
   function automatic void apply_request(input request_type it);
      int n, i, j, k;
      logic [mae_pkg::VAL_W-1:0] acc;
      elem_type e;
      n = (size_reg == '0) ? 1 :
          ((size_reg > mae_pkg::SIZE_W'(mae_pkg::MAX_DIM)) ? mae_pkg::MAX_DIM
                                                           : int'(size_reg));
      case (it.kind)
         mae_pkg::KIND_LOAD_A: begin
            if (it.row < mae_pkg::MAX_DIM && it.col < mae_pkg::MAX_DIM)
               mat_a[it.row][it.col] = it.value;
         end
         mae_pkg::KIND_LOAD_B: begin
            if (it.row < mae_pkg::MAX_DIM && it.col < mae_pkg::MAX_DIM)
               mat_b[it.row][it.col] = it.value;
         end
         mae_pkg::KIND_LOAD_C: begin
            if (it.row < mae_pkg::MAX_DIM)
               vec_c[it.row] = it.value;
         end
         default: begin
            if (it.op == mae_pkg::OP_AC || it.op == mae_pkg::OP_BC) begin
               for (i = 0; i < n; i++) begin
                  acc = '0;
                  for (k = 0; k < n; k++)
                     acc += ((it.op == mae_pkg::OP_AC) ? mat_a[i][k] : mat_b[i][k]) *
                            vec_c[k];
                  e.row = mae_pkg::POS_W'(i);
                  e.col = '0;
                  e.value = acc;
                  e.last = (i == n - 1);
                  expected_elems.push_back(e);
               end
            end else if (it.op != OP_NONE) begin
               for (i = 0; i < n; i++) begin
                  for (j = 0; j < n; j++) begin
                     case (it.op)
                        mae_pkg::OP_ADD: acc = mat_a[i][j] + mat_b[i][j];
                        mae_pkg::OP_SUB: acc = mat_a[i][j] - mat_b[i][j];
                        mae_pkg::OP_AB: begin
                           acc = '0;
                           for (k = 0; k < n; k++)
                              acc += mat_a[i][k] * mat_b[k][j];
                        end
                        mae_pkg::OP_TRA: acc = mat_a[j][i];
                        default: acc = mat_b[j][i];
                     endcase
                     e.row = mae_pkg::POS_W'(i);
                     e.col = mae_pkg::POS_W'(j);
                     e.value = acc;
                     e.last = (i == n - 1) && (j == n - 1);
                     expected_elems.push_back(e);
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic void note_error(input string msg);
      err_count++;
      if (err_count <= 10)
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endfunction

   function automatic void push_req(input logic [mae_pkg::KIND_W-1:0] kind,
                                    input int row, input int col,
                                    input logic [mae_pkg::VAL_W-1:0] value,
                                    input logic [mae_pkg::OP_W-1:0] op);
      request_type it;
      it.kind = kind;
      it.row = mae_pkg::POS_W'(row);
      it.col = mae_pkg::POS_W'(col);
      it.value = value;
      it.op = op;
      pending_reqs.push_back(it);
   endfunction

   // Waits until every request has gone in and every element has come out,
   // then gives the pipeline time to finish a request that yields nothing.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_reqs.size() > 0 || req_tvalid || expected_elems.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver.
   request_type req_cur;
   int          req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(req_cur);
            req_gap = draw_wait();
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_cur = pending_reqs.pop_front();
               req_tdata <= {7'd0, req_cur.op, req_cur.value, req_cur.col, req_cur.row};
               req_tuser <= req_cur.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. A long hold-off after the 30th and 300th element lets the
   // result queue fill so that the engine has to stall its request input.
   elem_type rsp_got;
   elem_type rsp_want;
   int       rsp_wait = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_got.row = rsp_tdata[2:0];
            rsp_got.col = rsp_tdata[5:3];
            rsp_got.value = rsp_tdata[37:6];
            rsp_got.last = rsp_tlast;
            if (expected_elems.size() == 0) begin
               note_error($sformatf("unexpected result row %0d col %0d value %h last %b",
                                    rsp_got.row, rsp_got.col, rsp_got.value, rsp_got.last));
            end else begin
               rsp_want = expected_elems.pop_front();
               if (rsp_got !== rsp_want)
                  note_error($sformatf({"expected row %0d col %0d value %h last %b, ",
                                        "got row %0d col %0d value %h last %b"},
                                       rsp_want.row, rsp_want.col, rsp_want.value,
                                       rsp_want.last, rsp_got.row, rsp_got.col,
                                       rsp_got.value, rsp_got.last));
            end
            rsp_seen++;
            rsp_wait = (rsp_seen == 30 || rsp_seen == 300) ? HOLD_CYCLES : draw_wait();
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   logic [mae_pkg::SIZE_W-1:0] size_plan [7] = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd2, 4'd3, 4'd4};

   initial begin
      request_type it;
      int p, i;
      for (i = 0; i < mae_pkg::MAX_DIM * mae_pkg::MAX_DIM; i++) begin
         mat_a[i / mae_pkg::MAX_DIM][i % mae_pkg::MAX_DIM] = '0;
         mat_b[i / mae_pkg::MAX_DIM][i % mae_pkg::MAX_DIM] = '0;
      end
      for (i = 0; i < mae_pkg::MAX_DIM; i++)
         vec_c[i] = '0;
      size_reg = mae_pkg::SIZE_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Every operation on the cleared stores, then corner loads and every
      // operation again, including the undefined code that yields nothing.
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_ADD);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_SUB);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_AB);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_AC);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_BC);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_TRA);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_TRB);
      push_req(mae_pkg::KIND_LOAD_A, 0, 0, 32'h7fff_ffff, OP_NONE);
      push_req(mae_pkg::KIND_LOAD_A, 3, 3, 32'h8000_0000, mae_pkg::OP_ADD);
      push_req(mae_pkg::KIND_LOAD_B, 0, 0, 32'hffff_ffff, OP_NONE);
      push_req(mae_pkg::KIND_LOAD_B, 3, 3, 32'h8000_0000, mae_pkg::OP_SUB);
      push_req(mae_pkg::KIND_LOAD_C, 0, 5, 32'hffff_ffff, OP_NONE);
      push_req(mae_pkg::KIND_LOAD_C, 3, 0, 32'h7fff_ffff, mae_pkg::OP_AB);
      // Loads outside the built store must be dropped.
      push_req(mae_pkg::KIND_LOAD_A, 4, 0, 32'h1234_5678, OP_NONE);
      push_req(mae_pkg::KIND_LOAD_B, 0, 7, 32'hdead_beef, OP_NONE);
      push_req(mae_pkg::KIND_LOAD_C, 7, 7, 32'h5555_aaaa, OP_NONE);
      push_req(mae_pkg::KIND_COMPUTE, 7, 7, 32'hffff_ffff, mae_pkg::OP_ADD);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_SUB);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_AB);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_AC);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_BC);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_TRA);
      push_req(mae_pkg::KIND_COMPUTE, 0, 0, '0, mae_pkg::OP_TRB);
      push_req(mae_pkg::KIND_COMPUTE, 5, 2, 32'h0f0f_0f0f, OP_NONE);
      wait_drained();

      for (p = 0; p < 7; p++) begin
         idle_mode = (p % 2 == 0);
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_wr_data <= size_plan[p];
         size_reg = size_plan[p];
         @(posedge clock);
         csr_wr_en <= 1'b0;

         // Mostly in-range loads and valid operations so that results keep
         // flowing; a few requests fall outside the store or use no operation.
         for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            it.row = mae_pkg::POS_W'($urandom_range(0, mae_pkg::MAX_DIM - 1));
            it.col = mae_pkg::POS_W'($urandom_range(0, mae_pkg::MAX_DIM - 1));
            it.value = draw_value();
            if ($urandom_range(0, 99) < 65) begin
               it.kind = mae_pkg::KIND_W'($urandom_range(0, 2));
               it.op = mae_pkg::OP_W'($urandom_range(0, 7));
               if ($urandom_range(0, 9) == 0) begin
                  it.row = mae_pkg::POS_W'($urandom_range(0, 7));
                  it.col = mae_pkg::POS_W'($urandom_range(0, 7));
               end
            end else begin
               it.kind = mae_pkg::KIND_COMPUTE;
               it.op = ($urandom_range(0, 14) == 0) ? OP_NONE
                                                     : mae_pkg::OP_W'($urandom_range(0, 6));
               it.row = mae_pkg::POS_W'($urandom_range(0, 7));
               it.col = mae_pkg::POS_W'($urandom_range(0, 7));
            end
            pending_reqs.push_back(it);
         end
         wait_drained();
      end

      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/mae_pkg.sv
design/matrix_arith_engine.sv
verif/matrix_arith_engine_tb.sv
